>>> sv/rca_pkg.sv
// Shared types, constants and arithmetic helpers for the running covariance accumulator.
// No dependencies; every other file in sv/ refers to this package by scoped names.
`timescale 1ns / 1ps

package rca_pkg;

  // Default vector length and index width of the query fields
  localparam int DIMS_DEF = 8;
  localparam int IDX_W    = 3;

  // Bit-serial divider numerator width
  localparam int DIV_W = 80;

  // One in Q16.16 / Q1.16
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Action codes
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_DECAY = 2'd2;

  // Command from the sequencer to every lane
  typedef struct packed {
    logic              add;
    logic              dec;
    logic [IDX_W-1:0]  col;
    logic [16:0]       f;
  } lane_cmd_t;

  // One entry read out of a lane
  typedef struct packed {
    logic [31:0] cnt;
    logic [63:0] psum;
    logic [47:0] vsum;
  } rd_t;

  // Scale a signed sum by a Q1.16 factor, truncating toward zero
  function automatic logic [63:0] scale_sum(input logic signed [63:0] s, input logic [16:0] f);
    logic [63:0] m;
    logic [63:0] res;
    logic [48:0] hp;
    logic [48:0] lp;
    m   = s[63] ? (~s + 64'd1) : s;
    hp  = 49'(m[63:32]) * 49'(f);
    lp  = 49'(m[31:0]) * 49'(f);
    res = {hp[47:0], 16'b0} + {31'b0, lp[48:16]};
    return s[63] ? (~res + 64'd1) : res;
  endfunction

endpackage

>>> sv/running_covariance_accumulator_top.sv
// Running covariance accumulator: input sequencer, lanes, merge and query arithmetic.
// Depends on rca_pkg, rca_lane, rca_merge and rca_div.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_*): one action per transfer. An add sample is absorbed at the
//   transfer edge and the block can take another item the next cycle. A decay walks
//   the columns of all lanes in turn. A query reads three entries, then runs three
//   divisions on the shared bit-serial divider, a partial-product multiply and,
//   unless the difference saturates, a fourth division; out_valid rises in the same
//   cycle that the next item can be taken. A query with too small a count, or with
//   an index out of range, skips the arithmetic and returns an unknown result.
//   Result channel (out_*): one result per query, none for add or decay. The result
//   register lets the next item be taken while a result waits; a query that finishes
//   while the previous result is still stalled holds until out_stall drops.
//   Configuration: cfg_wr_en writes cfg_wr_data into the decay factor (Q1.16).
//   Reset (rst_n low, synchronous) clears all counts and sums, sets the factor to 1.0
//   and drops out_valid.
module running_covariance_accumulator_top #(
  parameter int DIMS = rca_pkg::DIMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [15:0] in_sample_0,
  input  logic signed [15:0] in_sample_1,
  input  logic signed [15:0] in_sample_2,
  input  logic signed [15:0] in_sample_3,
  input  logic signed [15:0] in_sample_4,
  input  logic signed [15:0] in_sample_5,
  input  logic signed [15:0] in_sample_6,
  input  logic signed [15:0] in_sample_7,
  input  logic [7:0]         in_missing_mask,
  input  logic [2:0]         in_row_index,
  input  logic [2:0]         in_col_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_covariance,
  output logic               out_unknown,
  output logic               out_saturated,
  input  logic               cfg_wr_en,
  input  logic [16:0]        cfg_wr_data
);

  localparam int IXW = rca_pkg::IDX_W;
  localparam int DW  = rca_pkg::DIV_W;
  localparam logic [IXW:0] DIMS_N = (IXW + 1)'(DIMS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DECAY = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_DIVA  = 4'd4;
  localparam logic [3:0] S_DIVR  = 4'd5;
  localparam logic [3:0] S_DIVC  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_SUB   = 4'd8;
  localparam logic [3:0] S_RANGE = 4'd9;
  localparam logic [3:0] S_MULN  = 4'd10;
  localparam logic [3:0] S_DIVQ  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]          state_r, state_nxt;
  logic [2:0]          step_r;
  logic [16:0]         factor_r;
  logic [16:0]         f_clamp;
  logic signed [15:0]  s8  [8];
  logic signed [15:0]  smp [DIMS];
  rca_pkg::lane_cmd_t  lane_cmd;
  rca_pkg::rd_t        lane_rd [DIMS];
  rca_pkg::rd_t        mrg;
  logic [IXW-1:0]      rd_col, rd_lane;
  logic                idx_bad;
  logic                div_start, div_done;
  logic [DW-1:0]       div_num, div_quo;
  logic [31:0]         div_den;

  logic [IXW-1:0]      qr_r, qc_r;
  logic [31:0]         n_r, nr_r, nc_r;
  logic [63:0]         ps_r;
  logic [47:0]         vsr_r, vsc_r;
  logic [63:0]         a_r;
  logic [55:0]         mr_r, mc_r;
  logic [55:0]         pp_r;
  logic [1:0]          ppk_r;
  logic [111:0]        acc_r;
  logic [111:0]        pp_sh;
  logic [97:0]         d_r;
  logic [63:0]         dmn_r;
  logic [31:0]         cov_res_r;
  logic                unk_res_r, sat_res_r;
  logic                out_valid_r, out_unknown_r, out_saturated_r;
  logic [31:0]         out_cov_r;

  logic [63:0]         ps_mag;
  logic [47:0]         vsr_mag, vsc_mag;
  logic                low_cnt;
  logic [27:0]         pa, pb;
  logic [97:0]         a_s, b_s;
  logic                dneg, pos_sat, neg_sat;
  logic [31:0]         dm32, lim, qc32;
  logic                qover;

  // Gather sample ports into the lane vector
  always_comb begin
    s8[0] = in_sample_0; s8[1] = in_sample_1; s8[2] = in_sample_2; s8[3] = in_sample_3;
    s8[4] = in_sample_4; s8[5] = in_sample_5; s8[6] = in_sample_6; s8[7] = in_sample_7;
    for (int k = 0; k < DIMS; k++) smp[k] = s8[k];
  end

  // Decay factor register; clamp to 1.0 on use
  always_ff @(posedge clk) begin
    if (!rst_n) factor_r <= rca_pkg::ONE_Q16;
    else if (cfg_wr_en) factor_r <= cfg_wr_data;
  end
  assign f_clamp = (factor_r > rca_pkg::ONE_Q16) ? rca_pkg::ONE_Q16 : factor_r;

  // Lanes and merge
  for (genvar g = 0; g < DIMS; g++) begin : g_lane
    rca_lane #(.LANE(g), .DIMS(DIMS)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (lane_cmd),
      .x      (smp),
      .miss   (in_missing_mask[DIMS-1:0]),
      .rd_col (rd_col),
      .rd     (lane_rd[g])
    );
  end

  rca_merge #(.DIMS(DIMS)) u_merge (
    .clk     (clk),
    .lane_rd (lane_rd),
    .rd_lane (rd_lane),
    .rd      (mrg)
  );

  rca_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Operand shaping
  always_comb begin
    idx_bad = ({1'b0, in_row_index} >= DIMS_N) || ({1'b0, in_col_index} >= DIMS_N);
    ps_mag  = ps_r[63] ? (~ps_r + 64'd1) : ps_r;
    vsr_mag = vsr_r[47] ? (~vsr_r + 48'd1) : vsr_r;
    vsc_mag = vsc_r[47] ? (~vsc_r + 48'd1) : vsc_r;
    low_cnt = (n_r <= 32'(rca_pkg::ONE_Q16)) || (nr_r <= 32'(rca_pkg::ONE_Q16)) ||
              (nc_r <= 32'(rca_pkg::ONE_Q16));
    pa      = step_r[1] ? mr_r[55:28] : mr_r[27:0];
    pb      = step_r[0] ? mc_r[55:28] : mc_r[27:0];
    case (ppk_r) inside
      2'd0:       pp_sh = {56'b0, pp_r};
      2'd1, 2'd2: pp_sh = {28'b0, pp_r, 28'b0};
      default:    pp_sh = {pp_r, 56'b0};
    endcase
    a_s     = ps_r[63] ? (~{34'b0, a_r} + 98'd1) : {34'b0, a_r};
    b_s     = (vsr_r[47] ^ vsc_r[47]) ? (~{2'b0, acc_r[111:16]} + 98'd1)
                                      : {2'b0, acc_r[111:16]};
    dneg    = d_r[97];
    pos_sat = !dneg && (|d_r[96:31]);
    neg_sat = dneg && !(&d_r[96:31]);
    dm32    = dneg ? (~d_r[31:0] + 32'd1) : d_r[31:0];
    lim     = dneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    qover   = (|div_quo[DW-1:32]) || (div_quo[31:0] > lim);
    qc32    = qover ? lim : div_quo[31:0];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    rd_col        = '0;
    rd_lane       = '0;
    lane_cmd      = '0;
    lane_cmd.f    = f_clamp;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            rca_pkg::ACT_ADD:   lane_cmd.add = 1'b1;
            rca_pkg::ACT_QUERY: state_nxt = idx_bad ? S_OUT : S_READ;
            rca_pkg::ACT_DECAY: state_nxt = S_DECAY;
            default: ;
          endcase
        end
      end
      S_DECAY: begin
        lane_cmd.dec = 1'b1;
        lane_cmd.col = step_r;
        if (step_r == IXW'(DIMS - 1)) state_nxt = S_IDLE;
      end
      S_READ: begin
        case (step_r)
          3'd0: begin rd_lane = qr_r; rd_col = qc_r; end
          3'd1: begin rd_lane = qr_r; rd_col = qr_r; end
          default: begin rd_lane = qc_r; rd_col = qc_r; end
        endcase
        if (step_r == 3'd4) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (low_cnt) begin
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = {ps_mag, 16'b0};
          div_den   = n_r;
          state_nxt = S_DIVA;
        end
      end
      S_DIVA: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = {8'b0, vsr_mag, 24'b0};
          div_den   = nr_r;
          state_nxt = S_DIVR;
        end
      end
      S_DIVR: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = {8'b0, vsc_mag, 24'b0};
          div_den   = nc_r;
          state_nxt = S_DIVC;
        end
      end
      S_DIVC:  if (div_done) state_nxt = S_MUL;
      S_MUL:   if (step_r == 3'd4) state_nxt = S_SUB;
      S_SUB:   state_nxt = S_RANGE;
      S_RANGE: state_nxt = (pos_sat || neg_sat) ? S_OUT : S_MULN;
      S_MULN: begin
        div_start = 1'b1;
        div_num   = {16'b0, dmn_r};
        div_den   = n_r - 32'(rca_pkg::ONE_Q16);
        state_nxt = S_DIVQ;
      end
      S_DIVQ:  if (div_done) state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_nxt != state_r) ? 3'd0 : step_r + 3'd1;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Query datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && in_action == rca_pkg::ACT_QUERY) begin
      qr_r      <= (in_col_index < in_row_index) ? in_col_index : in_row_index;
      qc_r      <= (in_col_index < in_row_index) ? in_row_index : in_col_index;
      cov_res_r <= '0;
      unk_res_r <= 1'b1;
      sat_res_r <= 1'b0;
    end
    if (state_r == S_READ) begin
      if (step_r == 3'd2) begin
        n_r   <= mrg.cnt;
        ps_r  <= mrg.psum;
        vsr_r <= mrg.vsum;
      end
      if (step_r == 3'd3) nr_r <= mrg.cnt;
      if (step_r == 3'd4) begin
        nc_r  <= mrg.cnt;
        vsc_r <= mrg.vsum;
      end
    end
    if (state_r == S_DIVA && div_done) a_r <= div_quo[63:0];
    if (state_r == S_DIVR && div_done) mr_r <= div_quo[55:0];
    if (state_r == S_DIVC && div_done) begin
      mc_r  <= div_quo[55:0];
      acc_r <= '0;
    end
    if (state_r == S_MUL) begin
      if (step_r != 3'd4) begin
        pp_r  <= pa * pb;
        ppk_r <= step_r[1:0];
      end
      if (step_r != 3'd0) acc_r <= acc_r + pp_sh;
    end
    if (state_r == S_SUB) d_r <= a_s - b_s;
    if (state_r == S_RANGE) begin
      if (pos_sat) begin
        cov_res_r <= 32'h7FFF_FFFF;
        unk_res_r <= 1'b0;
        sat_res_r <= 1'b1;
      end else if (neg_sat) begin
        cov_res_r <= 32'h8000_0000;
        unk_res_r <= 1'b0;
        sat_res_r <= 1'b1;
      end else begin
        dmn_r <= dm32 * n_r;
      end
    end
    if (state_r == S_DIVQ && div_done) begin
      cov_res_r <= dneg ? (~qc32 + 32'd1) : qc32;
      unk_res_r <= 1'b0;
      sat_res_r <= qover;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && state_nxt == S_IDLE) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && state_nxt == S_IDLE) begin
      out_cov_r       <= cov_res_r;
      out_unknown_r   <= unk_res_r;
      out_saturated_r <= sat_res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_covariance = out_cov_r;
  assign out_unknown    = out_unknown_r;
  assign out_saturated  = out_saturated_r;

`ifndef SYNTHESIS
  // A result appears only out of the result state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside result state");

  // Leaving the result state always leaves a pending result
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && state_nxt == S_IDLE) |=> out_valid_r)
    else $error("query finished without a result");

  // An unknown result is never flagged as clipped
  a_unk_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_unknown_r && out_saturated_r))
    else $error("unknown and saturated both set");
`endif

endmodule

>>> sv/rca_lane.sv
// One accumulator lane: counts and product sums of row LANE of the upper triangle,
// plus the value sum of element LANE. Depends on rca_pkg.
`timescale 1ns / 1ps

module rca_lane #(
  parameter int LANE = 0,
  parameter int DIMS = rca_pkg::DIMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rca_pkg::lane_cmd_t             cmd,
  input  logic signed [15:0]             x [DIMS],
  input  logic [DIMS-1:0]                miss,
  input  logic [rca_pkg::IDX_W-1:0]      rd_col,
  output rca_pkg::rd_t                   rd
);

  localparam int IW = (DIMS > 1) ? $clog2(DIMS) : 1;

  logic [31:0]        cnt_r   [DIMS];
  logic [63:0]        psum_r  [DIMS];
  logic [47:0]        vsum_r;
  logic [31:0]        cnt_nxt [DIMS];
  logic [63:0]        psum_nxt[DIMS];
  logic [47:0]        vsum_nxt;
  logic signed [31:0] prod    [DIMS];
  logic [64:0]        ps_sum  [DIMS];
  logic [48:0]        cm      [DIMS];
  logic [48:0]        vs_sum;
  logic [63:0]        vs_sc;
  rca_pkg::rd_t       rd_r;

  // Add a sample or scale one column per cycle
  always_comb begin
    for (int j = 0; j < DIMS; j++) begin
      prod[j]     = 32'(x[LANE]) * 32'(x[j]);
      ps_sum[j]   = {psum_r[j][63], psum_r[j]} + 65'(prod[j]);
      cm[j]       = 49'(cnt_r[j]) * 49'(cmd.f);
      cnt_nxt[j]  = cnt_r[j];
      psum_nxt[j] = psum_r[j];
      if (cmd.add && !miss[LANE] && !miss[j] && (j >= LANE)) begin
        cnt_nxt[j] = (cnt_r[j] > 32'hFFFE_FFFF) ? 32'hFFFF_FFFF : cnt_r[j] + 32'h0001_0000;
        if (ps_sum[j][64] != ps_sum[j][63]) begin
          psum_nxt[j] = ps_sum[j][64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end else begin
          psum_nxt[j] = ps_sum[j][63:0];
        end
      end
      if (cmd.dec && (cmd.col[IW-1:0] == IW'(j)) && (j >= LANE)) begin
        cnt_nxt[j]  = cm[j][47:16];
        psum_nxt[j] = rca_pkg::scale_sum(psum_r[j], cmd.f);
      end
    end
    vs_sum   = {vsum_r[47], vsum_r} + 49'(x[LANE]);
    vs_sc    = rca_pkg::scale_sum(64'($signed(vsum_r)), cmd.f);
    vsum_nxt = vsum_r;
    if (cmd.add && !miss[LANE]) begin
      if (vs_sum[48] != vs_sum[47]) begin
        vsum_nxt = vs_sum[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      end else begin
        vsum_nxt = vs_sum[47:0];
      end
    end
    if (cmd.dec && (cmd.col[IW-1:0] == '0)) begin
      vsum_nxt = vs_sc[47:0];
    end
  end

  // Hold the accumulators; clear at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIMS; j++) begin
        cnt_r[j]  <= '0;
        psum_r[j] <= '0;
      end
      vsum_r <= '0;
    end else begin
      for (int j = 0; j < DIMS; j++) begin
        cnt_r[j]  <= cnt_nxt[j];
        psum_r[j] <= psum_nxt[j];
      end
      vsum_r <= vsum_nxt;
    end
  end

  // Registered read of one column
  always_ff @(posedge clk) begin
    rd_r.cnt  <= cnt_r[rd_col[IW-1:0]];
    rd_r.psum <= psum_r[rd_col[IW-1:0]];
    rd_r.vsum <= vsum_r;
  end

  assign rd = rd_r;

endmodule

>>> sv/rca_merge.sv
// Merging stage: picks the read data of one lane and registers it.
// Depends on rca_pkg.
`timescale 1ns / 1ps

module rca_merge #(
  parameter int DIMS = rca_pkg::DIMS_DEF
) (
  input  logic                      clk,
  input  rca_pkg::rd_t              lane_rd [DIMS],
  input  logic [rca_pkg::IDX_W-1:0] rd_lane,
  output rca_pkg::rd_t              rd
);

  localparam int IW = (DIMS > 1) ? $clog2(DIMS) : 1;

  logic [rca_pkg::IDX_W-1:0] sel_r;
  rca_pkg::rd_t              rd_r;

  // Align the lane select with the lane read register, then select
  always_ff @(posedge clk) begin
    sel_r <= rd_lane;
    rd_r  <= lane_rd[sel_r[IW-1:0]];
  end

  assign rd = rd_r;

endmodule

>>> sv/rca_div.sv
// Restoring divider, one quotient bit per cycle: unsigned DIV_W-bit numerator by 32 bits.
// Depends on rca_pkg.
`timescale 1ns / 1ps

module rca_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rca_pkg::DIV_W-1:0] num,
  input  logic [31:0]               den,
  output logic                      done,
  output logic [rca_pkg::DIV_W-1:0] quo
);

  localparam int W  = rca_pkg::DIV_W;
  localparam int CW = $clog2(W);

  logic [W-1:0]  quo_r;
  logic [31:0]   rem_r;
  logic [31:0]   den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [32:0]   rem_sh;
  logic          q_bit;
  logic [32:0]   rem_sub;

  // Shift in one numerator bit, subtract when it fits
  always_comb begin
    rem_sh  = {rem_r, quo_r[W-1]};
    q_bit   = (rem_sh >= {1'b0, den_r});
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (cnt_r == CW'(W - 1))) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> tb/running_covariance_accumulator_top_tb.sv
// Testbench for running_covariance_accumulator_top: random and directed actions with checking.
// Depends on rca_pkg and the block; holds its own covariance predictor in a scoreboard class.
`timescale 1ns / 1ps

module running_covariance_accumulator_top_tb;

  localparam int NPAIR = 36;
  localparam int SETTLE = 400;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic signed [63:0] VSUM_MAX = 64'sh7FFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]         action;
    logic signed [15:0] smp [8];
    logic [7:0]         mask;
    logic [2:0]         row;
    logic [2:0]         col;
  } action_t;

  typedef struct packed {
    logic signed [31:0] cov;
    logic               unk;
    logic               sat;
  } cov_result_t;

  // Holds the accumulator state and the queue of covariance results still owed
  class cov_scoreboard;
    logic [31:0]        cnt [NPAIR];
    logic signed [63:0] psum [NPAIR];
    logic signed [63:0] vsum [8];
    logic [16:0]        factor;
    cov_result_t        owed_q [$];
    int                 errors;

    function new();
      foreach (cnt[k]) begin
        cnt[k] = '0;
        psum[k] = '0;
      end
      foreach (vsum[k]) vsum[k] = '0;
      factor = rca_pkg::ONE_Q16;
      errors = 0;
    endfunction

    function int pair_at(int i, int j);
      return i * 8 - (i * (i - 1)) / 2 + (j - i);
    endfunction

    function logic [63:0] mag(logic signed [63:0] s);
      return s < 0 ? -s : s;
    endfunction

    function logic signed [63:0] scale(logic signed [63:0] s, logic [16:0] f);
      logic [63:0] m;
      logic [63:0] res;
      m = mag(s);
      res = ((64'(m[63:32]) * 64'(f)) << 16) + ((64'(m[31:0]) * 64'(f)) >> 16);
      return s < 0 ? -res : res;
    endfunction

    function void accumulate(action_t it);
      logic signed [63:0] xi;
      logic signed [63:0] xj;
      logic signed [63:0] v;
      logic signed [63:0] prod;
      logic signed [64:0] s;
      int p;
      for (int i = 0; i < 8; i++) begin
        if (it.mask[i]) continue;
        xi = 64'(it.smp[i]);
        v = vsum[i] + xi;
        if (v > VSUM_MAX) v = VSUM_MAX;
        if (v < -VSUM_MAX - 1) v = -VSUM_MAX - 1;
        vsum[i] = v;
        for (int j = i; j < 8; j++) begin
          if (it.mask[j]) continue;
          xj = 64'(it.smp[j]);
          p = pair_at(i, j);
          cnt[p] = (cnt[p] > 32'hFFFF_FFFF - 32'd65536) ? 32'hFFFF_FFFF : cnt[p] + 32'd65536;
          prod = xi * xj;
          s = 65'(psum[p]) + 65'(prod);
          if (s[64] != s[63]) psum[p] = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          else psum[p] = s[63:0];
        end
      end
    endfunction

    function void decay_all();
      logic [16:0] f;
      logic [63:0] t;
      f = factor > rca_pkg::ONE_Q16 ? rca_pkg::ONE_Q16 : factor;
      for (int k = 0; k < NPAIR; k++) begin
        t = 64'(cnt[k]) * 64'(f);
        cnt[k] = t[47:16];
        psum[k] = scale(psum[k], f);
      end
      for (int k = 0; k < 8; k++) vsum[k] = scale(vsum[k], f);
    endfunction

    function cov_result_t covariance_of(int r, int c);
      cov_result_t res;
      int t;
      int p;
      logic [63:0] n, nr, nc, dm, q, lim;
      logic [127:0] am, mrm, mcm, b, d;
      logic signed [127:0] ds;
      res = '{cov: '0, unk: 1'b1, sat: 1'b0};
      if (c < r) begin
        t = r;
        r = c;
        c = t;
      end
      p = pair_at(r, c);
      n = 64'(cnt[p]);
      nr = 64'(cnt[pair_at(r, r)]);
      nc = 64'(cnt[pair_at(c, c)]);
      if (n <= 65536 || nr <= 65536 || nc <= 65536) return res;
      am = ({64'b0, mag(psum[p])} << 16) / {64'b0, n};
      if (psum[p] < 0) am = -am;
      mrm = ({64'b0, mag(vsum[r])} << 24) / {64'b0, nr};
      mcm = ({64'b0, mag(vsum[c])} << 24) / {64'b0, nc};
      b = ({64'b0, mrm[63:0]} * {64'b0, mcm[63:0]}) >> 16;
      if ((vsum[r] < 0) != (vsum[c] < 0)) b = -b;
      d = am - b;
      ds = d;
      res.unk = 1'b0;
      if (ds > 128'sd2147483647) begin
        res.cov = 32'h7FFF_FFFF;
        res.sat = 1'b1;
      end else if (ds < -128'sd2147483648) begin
        res.cov = 32'h8000_0000;
        res.sat = 1'b1;
      end else begin
        dm = ds < 0 ? 64'(-ds) : 64'(ds);
        q = (dm * n) / (n - 64'd65536);
        lim = ds < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > lim) begin
          q = lim;
          res.sat = 1'b1;
        end
        res.cov = ds < 0 ? 32'(-q) : 32'(q);
      end
      return res;
    endfunction

    // Advance the state for one accepted transfer
    function void note_input(action_t it);
      case (it.action)
        rca_pkg::ACT_ADD: accumulate(it);
        rca_pkg::ACT_DECAY: decay_all();
        rca_pkg::ACT_QUERY: owed_q.push_back(covariance_of(int'(it.row), int'(it.col)));
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(cov_result_t got);
      cov_result_t want;
      if (owed_q.size() == 0) begin
        report("result with nothing owed");
        return;
      end
      want = owed_q.pop_front();
      if (got.cov !== want.cov) report($sformatf("covariance %0d, want %0d", got.cov, want.cov));
      if (got.unk !== want.unk) report($sformatf("unknown %0b, want %0b", got.unk, want.unk));
      if (got.sat !== want.sat) report($sformatf("saturated %0b, want %0b", got.sat, want.sat));
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_action;
  logic signed [15:0] in_sample [8];
  logic [7:0]         in_missing_mask;
  logic [2:0]         in_row_index;
  logic [2:0]         in_col_index;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_covariance;
  logic               out_unknown;
  logic               out_saturated;
  logic               cfg_wr_en;
  logic [16:0]        cfg_wr_data;

  cov_scoreboard sb = new();
  int hold_left = 0;

  running_covariance_accumulator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_sample_0(in_sample[0]), .in_sample_1(in_sample[1]),
    .in_sample_2(in_sample[2]), .in_sample_3(in_sample[3]),
    .in_sample_4(in_sample[4]), .in_sample_5(in_sample[5]),
    .in_sample_6(in_sample[6]), .in_sample_7(in_sample[7]),
    .in_missing_mask(in_missing_mask), .in_row_index(in_row_index),
    .in_col_index(in_col_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_covariance(out_covariance),
    .out_unknown(out_unknown), .out_saturated(out_saturated),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // Watch both channels; values read here are the ones present before the edge
  always @(posedge clk) begin
    action_t seen;
    if (rst_n && in_valid && !in_stall) begin
      seen.action = in_action;
      for (int k = 0; k < 8; k++) seen.smp[k] = in_sample[k];
      seen.mask = in_missing_mask;
      seen.row = in_row_index;
      seen.col = in_col_index;
      sb.note_input(seen);
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{cov: out_covariance, unk: out_unknown, sat: out_saturated});
  end

  // Receiver stall pattern, with a long hold-off when asked
  initial begin
    int mode;
    int tick;
    mode = 0;
    tick = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 9) != 0);
          default: out_stall <= (tick % 3 == 0);
        endcase
      end
      tick++;
      if (tick % 97 == 0) mode = $urandom_range(0, 3);
    end
  end

  // Present one item and hold it until the transfer; valid stays high on return
  task automatic send(action_t it);
    in_valid <= 1'b1;
    in_action <= it.action;
    for (int k = 0; k < 8; k++) in_sample[k] <= it.smp[k];
    in_missing_mask <= it.mask;
    in_row_index <= it.row;
    in_col_index <= it.col;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drop_and_idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic action_t make_item(logic [1:0] act, logic signed [15:0] fill,
                                        logic [7:0] mask, logic [2:0] r, logic [2:0] c);
    action_t it;
    it.action = act;
    for (int k = 0; k < 8; k++) it.smp[k] = fill;
    it.mask = mask;
    it.row = r;
    it.col = c;
    return it;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 2047) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic action_t rand_item(int query_weight);
    action_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < query_weight) it.action = rca_pkg::ACT_QUERY;
    else if (pick < query_weight + 8) it.action = rca_pkg::ACT_DECAY;
    else if (pick < query_weight + 13) it.action = ACT_NONE;
    else it.action = rca_pkg::ACT_ADD;
    for (int k = 0; k < 8; k++) it.smp[k] = rand_sample();
    case ($urandom_range(0, 6))
      0, 1: it.mask = 8'($urandom);
      2: it.mask = 8'd1 << $urandom_range(0, 7);
      default: it.mask = 8'd0;
    endcase
    it.row = 3'($urandom_range(0, 7));
    it.col = 3'($urandom_range(0, 7));
    return it;
  endfunction

  // Wait for every owed result, then let any add or decay finish
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_factor(logic [16:0] f);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    sb.factor = f;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic directed();
    action_t it;
    send(make_item(rca_pkg::ACT_QUERY, 16'sd0, 8'h00, 3'd0, 3'd0));
    send(make_item(rca_pkg::ACT_ADD, 16'sh7FFF, 8'h00, 3'd0, 3'd0));
    send(make_item(rca_pkg::ACT_ADD, 16'sh8000, 8'h00, 3'd0, 3'd0));
    send(make_item(rca_pkg::ACT_ADD, 16'sh0100, 8'hAA, 3'd0, 3'd0));
    send(make_item(rca_pkg::ACT_ADD, -16'sd1, 8'h55, 3'd0, 3'd0));
    send(make_item(rca_pkg::ACT_ADD, 16'sd0, 8'hFF, 3'd0, 3'd0));
    send(make_item(rca_pkg::ACT_QUERY, 16'sd0, 8'h00, 3'd0, 3'd0));
    send(make_item(rca_pkg::ACT_QUERY, 16'sd0, 8'h00, 3'd7, 3'd0));
    send(make_item(rca_pkg::ACT_QUERY, 16'sd0, 8'h00, 3'd0, 3'd7));
    send(make_item(rca_pkg::ACT_QUERY, 16'sd0, 8'h00, 3'd3, 3'd5));
    send(make_item(ACT_NONE, 16'sh1234, 8'h0F, 3'd1, 3'd2));
    send(make_item(rca_pkg::ACT_DECAY, 16'sd0, 8'h00, 3'd0, 3'd0));
    send(make_item(rca_pkg::ACT_QUERY, 16'sd0, 8'h00, 3'd7, 3'd7));
    it = make_item(rca_pkg::ACT_ADD, 16'sd0, 8'h00, 3'd0, 3'd0);
    for (int k = 0; k < 8; k++) it.smp[k] = (k % 2) ? 16'sh7FFF : 16'sh8000;
    send(it);
    send(make_item(rca_pkg::ACT_ADD, 16'sh0080, 8'h00, 3'd0, 3'd0));
    send(make_item(rca_pkg::ACT_QUERY, 16'sd0, 8'h00, 3'd6, 3'd2));
    send(make_item(rca_pkg::ACT_QUERY, 16'sd0, 8'h00, 3'd1, 3'd1));
    in_valid <= 1'b0;
  endtask

  // Bursts with random gaps; some gaps are empty so stretches run back to back
  task automatic run_random(int count, int query_weight);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && left > 0; k++) begin
        send(rand_item(query_weight));
        left--;
      end
      if ($urandom_range(0, 3) != 0 && left > 0) drop_and_idle($urandom_range(1, 8));
    end
    in_valid <= 1'b0;
  endtask

  // Hold the result side off while queries keep coming so the input backs up
  task automatic backpressure();
    action_t it;
    for (int k = 0; k < 4; k++) send(rand_item(0) );
    hold_left = 1500;
    for (int k = 0; k < 12; k++) begin
      it = rand_item(100);
      send(it);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [16:0] factors [6];
    factors = '{17'd65536, 17'd0, 17'd32768, 17'd1, 17'd65535, 17'd60000};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= rca_pkg::ACT_ADD;
    for (int k = 0; k < 8; k++) in_sample[k] <= '0;
    in_missing_mask <= '0;
    in_row_index <= '0;
    in_col_index <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_factor(ph == 5 ? 17'($urandom_range(0, 65536)) : factors[ph]);
      if (ph == 2) begin
        backpressure();
        wait_idle();
      end
      run_random(190, 30);
    end
    wait_idle();
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
